// ----- rtl/tttr_pkg.sv -----
// ----------------------------------------------------------------------------
// tttr_pkg
// Shared types and constants for the time-tag record decoder: record field
// positions, wrap factors, result kinds and the command word that travels
// from the front end to the execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

package tttr_pkg;

  // record layout
  localparam int unsigned RECORD_W  = 32;
  localparam int unsigned CHAN_W    = 6;
  localparam int unsigned TAG_W     = 25;
  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned FINE_W    = 15;
  localparam int unsigned FINE_LSB  = 10;

  // result fields and registers
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned OUT_CH_W  = 7;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned BIN_W     = 24;
  localparam int unsigned WRAP_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // overflow increment: widest tag times widest wrap factor
  localparam int unsigned ADDEND_W  = TAG_W + WRAP_W;
  localparam int unsigned FINE_PS_W = FINE_W + BIN_W;

  localparam logic [WRAP_W-1:0] ABS_WRAP   = 32'd33554432;
  localparam logic [WRAP_W-1:0] PULSE_WRAP = 32'd1024;

  localparam logic [CHAN_W-1:0] OVF_CHANNEL  = 6'd63;
  localparam logic [CHAN_W-1:0] SYNC_SPECIAL = 6'd0;

  localparam logic [KIND_W-1:0] KIND_EVENT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARKER   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_CHANNEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH    = 2'd2;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_EVENT_ABS,
    OP_EVENT_REL,
    OP_OVERFLOW,
    OP_MARKER
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [OUT_CH_W-1:0]  channel;
    logic [ADDEND_W-1:0]  addend;   // tag, pulse count or origin increment
    logic [FINE_PS_W-1:0] fine_ps;
    logic [CHAN_W-1:0]    marker;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/tttr_record_decoder.sv -----
// Path: an accepted word is written into the command queue and popped from it
// into the result register, which drives the result port.
// Throughput: one word per cycle while the result port is not held back; the
// execute stage does a single 64-bit add against the time origin per word, and
// the products are formed ahead of it. Reset (asynchronous, active low): time
// origin zero, queue and result register empty, decode mode absolute, sync channel 0, bin width 1 ps.
// ----------------------------------------------------------------------------
// tttr_record_decoder
// Photon time-tag record decoder: classifier, command queue, execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tttr_record_decoder #(
  parameter int unsigned FifoDepth = tttr_pkg::FIFO_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tttr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [tttr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [tttr_pkg::RECORD_W-1:0]     raw_record_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [tttr_pkg::KIND_W-1:0]            kind_o,
  output logic [tttr_pkg::OUT_CH_W-1:0]          channel_o,
  output logic [tttr_pkg::TIME_W-1:0]            event_time_o,
  output logic [tttr_pkg::TIME_W-1:0]            pulse_number_o,
  output logic [tttr_pkg::CHAN_W-1:0]            marker_bits_o
);

  tttr_pkg::cmd_t push_cmd;
  tttr_pkg::cmd_t head_cmd;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  tttr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_record_i (raw_record_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  tttr_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  tttr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (!empty),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .channel_o      (channel_o),
    .event_time_o   (event_time_o),
    .pulse_number_o (pulse_number_o),
    .marker_bits_o  (marker_bits_o)
  );

endmodule

`default_nettype wire

// ----- rtl/tttr_front.sv -----
// ----------------------------------------------------------------------------
// tttr_front
// Holds the configuration registers, classifies each record word and
// precomputes the products (origin increment, fine time in ps) so the
// execute stage only has one add left.
// ----------------------------------------------------------------------------
`default_nettype none

module tttr_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tttr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [tttr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [tttr_pkg::RECORD_W-1:0]       raw_record_i,
  input  wire logic                                full_i,
  output logic                                     push_o,
  output tttr_pkg::cmd_t                           cmd_o
);

  logic                              mode_q;
  logic [tttr_pkg::OUT_CH_W-1:0]     sync_ch_q;
  logic [tttr_pkg::BIN_W-1:0]        bin_width_q;

  logic                              special;
  logic [tttr_pkg::CHAN_W-1:0]       chan;
  logic [tttr_pkg::TAG_W-1:0]        tag;
  logic [tttr_pkg::COUNT_W-1:0]      count;
  logic [tttr_pkg::FINE_W-1:0]       fine;
  logic [tttr_pkg::TAG_W-1:0]        mul_a;
  logic [tttr_pkg::WRAP_W-1:0]       mul_b;
  logic [tttr_pkg::ADDEND_W-1:0]     ovf_inc;
  logic [tttr_pkg::FINE_PS_W-1:0]    fine_ps;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      sync_ch_q   <= '0;
      bin_width_q <= tttr_pkg::BIN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tttr_pkg::CFG_DECODE_MODE:  mode_q      <= cfg_wdata_i[0];
        tttr_pkg::CFG_SYNC_CHANNEL: sync_ch_q   <= cfg_wdata_i[tttr_pkg::OUT_CH_W-1:0];
        tttr_pkg::CFG_BIN_WIDTH:    bin_width_q <= cfg_wdata_i[tttr_pkg::BIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign special = raw_record_i[tttr_pkg::RECORD_W-1];
  assign chan    = raw_record_i[tttr_pkg::RECORD_W-2 -: tttr_pkg::CHAN_W];
  assign tag     = raw_record_i[tttr_pkg::TAG_W-1:0];
  assign count   = raw_record_i[tttr_pkg::COUNT_W-1:0];
  assign fine    = raw_record_i[tttr_pkg::FINE_LSB +: tttr_pkg::FINE_W];

  // one multiplier serves both overflow formats
  assign mul_a   = mode_q ? tttr_pkg::TAG_W'(count) : tag;
  assign mul_b   = mode_q ? tttr_pkg::PULSE_WRAP : tttr_pkg::ABS_WRAP;
  assign ovf_inc = tttr_pkg::ADDEND_W'(mul_a) * tttr_pkg::ADDEND_W'(mul_b);
  assign fine_ps = tttr_pkg::FINE_PS_W'(fine) * tttr_pkg::FINE_PS_W'(bin_width_q);

  always_comb begin
    cmd_o.op      = tttr_pkg::OP_EVENT_ABS;
    cmd_o.channel = tttr_pkg::OUT_CH_W'(chan);
    cmd_o.addend  = tttr_pkg::ADDEND_W'(tag);
    cmd_o.fine_ps = fine_ps;
    cmd_o.marker  = '0;
    if (special && chan == tttr_pkg::OVF_CHANNEL) begin
      cmd_o.op     = tttr_pkg::OP_OVERFLOW;
      cmd_o.addend = ovf_inc;
    end else if (special && !mode_q && chan == tttr_pkg::SYNC_SPECIAL) begin
      cmd_o.channel = sync_ch_q;
    end else if (special) begin
      cmd_o.op     = tttr_pkg::OP_MARKER;
      cmd_o.marker = chan;
    end else if (mode_q) begin
      cmd_o.op     = tttr_pkg::OP_EVENT_REL;
      cmd_o.addend = tttr_pkg::ADDEND_W'(count);
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

`default_nettype wire

// ----- rtl/tttr_fifo.sv -----
// ----------------------------------------------------------------------------
// tttr_fifo
// Short command queue between the classifier and the execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tttr_fifo #(
  parameter int unsigned Depth = tttr_pkg::FIFO_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire tttr_pkg::cmd_t data_i,
  input  wire logic   pop_i,
  output tttr_pkg::cmd_t data_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tttr_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue fill count missed a push");
`endif

endmodule

`default_nettype wire

// ----- rtl/tttr_back.sv -----
// ----------------------------------------------------------------------------
// tttr_back
// Execute stage: keeps the 64-bit time origin, adds it to the queued tag or
// pulse count, steps it on overflow words and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tttr_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire tttr_pkg::cmd_t                    cmd_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [tttr_pkg::KIND_W-1:0]            kind_o,
  output logic [tttr_pkg::OUT_CH_W-1:0]          channel_o,
  output logic [tttr_pkg::TIME_W-1:0]            event_time_o,
  output logic [tttr_pkg::TIME_W-1:0]            pulse_number_o,
  output logic [tttr_pkg::CHAN_W-1:0]            marker_bits_o
);

  logic                            out_valid_q;
  logic [tttr_pkg::TIME_W-1:0]     origin_q, origin_d;
  logic [tttr_pkg::TIME_W-1:0]     sum;
  logic [tttr_pkg::KIND_W-1:0]     kind_q, kind_d;
  logic [tttr_pkg::OUT_CH_W-1:0]   channel_q, channel_d;
  logic [tttr_pkg::TIME_W-1:0]     time_q, time_d;
  logic [tttr_pkg::TIME_W-1:0]     pulse_q, pulse_d;
  logic [tttr_pkg::CHAN_W-1:0]     marker_q, marker_d;

  assign pop_o = valid_i && (!out_valid_q || out_ready_i);
  assign sum   = origin_q + tttr_pkg::TIME_W'(cmd_i.addend);

  always_comb begin
    origin_d  = origin_q;
    kind_d    = tttr_pkg::KIND_EVENT;
    channel_d = '0;
    time_d    = '0;
    pulse_d   = '0;
    marker_d  = '0;
    unique case (cmd_i.op)
      tttr_pkg::OP_EVENT_ABS: begin
        channel_d = cmd_i.channel;
        time_d    = sum;
      end
      tttr_pkg::OP_EVENT_REL: begin
        channel_d = cmd_i.channel;
        time_d    = tttr_pkg::TIME_W'(cmd_i.fine_ps);
        pulse_d   = sum;
      end
      tttr_pkg::OP_OVERFLOW: begin
        kind_d = tttr_pkg::KIND_OVERFLOW;
        if (pop_o) begin
          origin_d = sum;
        end
      end
      tttr_pkg::OP_MARKER: begin
        kind_d   = tttr_pkg::KIND_MARKER;
        marker_d = cmd_i.marker;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      origin_q    <= '0;
    end else begin
      origin_q <= origin_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q    <= kind_d;
      channel_q <= channel_d;
      time_q    <= time_d;
      pulse_q   <= pulse_d;
      marker_q  <= marker_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign channel_o      = channel_q;
  assign event_time_o   = time_q;
  assign pulse_number_o = pulse_q;
  assign marker_bits_o  = marker_q;

`ifndef SYNTHESIS
  a_origin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_o && cmd_i.op == tttr_pkg::OP_OVERFLOW) |=> origin_q == $past(origin_q))
    else $error("time origin moved without an overflow word");

  a_origin_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.op == tttr_pkg::OP_OVERFLOW) |=>
      origin_q == $past(origin_q) + tttr_pkg::TIME_W'($past(cmd_i.addend)))
    else $error("time origin not advanced by overflow increment");
`endif

endmodule

`default_nettype wire

// ----- tb/tttr_record_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// tttr_record_decoder_tb
// Drives time-tag record words into the decoder and checks every result word
// against a cycle-free predictor that tracks the time origin and registers.
// A directed table walks the field extremes and the special records. Random
// streams follow under three idle patterns, with the registers rewritten
// between segments while the block is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tttr_record_decoder_tb;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [tttr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register here

  typedef struct packed {
    logic [tttr_pkg::KIND_W-1:0]   kind;
    logic [tttr_pkg::OUT_CH_W-1:0] channel;
    logic [tttr_pkg::TIME_W-1:0]   ev_time;
    logic [tttr_pkg::TIME_W-1:0]   pulse;
    logic [tttr_pkg::CHAN_W-1:0]   marker;
  } decoded_t;

  typedef struct packed {
    logic                            is_cfg;
    logic [tttr_pkg::CFG_IDX_W-1:0]  idx;
    logic [tttr_pkg::RECORD_W-1:0]   val;    // record word, or register data
    logic                            typed;  // res holds the expected result
    decoded_t                        res;
  } stim_row_t;

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            cfg_we_i     = 1'b0;
  logic [tttr_pkg::CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [tttr_pkg::CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_ready_o;
  logic [tttr_pkg::RECORD_W-1:0]   raw_record_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i  = 1'b0;
  logic [tttr_pkg::KIND_W-1:0]     kind_o;
  logic [tttr_pkg::OUT_CH_W-1:0]   channel_o;
  logic [tttr_pkg::TIME_W-1:0]     event_time_o;
  logic [tttr_pkg::TIME_W-1:0]     pulse_number_o;
  logic [tttr_pkg::CHAN_W-1:0]     marker_bits_o;

  // predictor state
  logic                            dec_mode_q = 1'b0;
  logic [tttr_pkg::OUT_CH_W-1:0]   sync_ch_q  = '0;
  logic [tttr_pkg::BIN_W-1:0]      bin_ps_q   = 24'd1;
  logic [tttr_pkg::TIME_W-1:0]     origin_q   = '0;

  decoded_t    pending_q[$];
  stim_row_t   dir_tab[$];
  int unsigned err_cnt   = 0;
  int unsigned cyc_cnt   = 0;
  int unsigned snd_idle  = 0;
  int unsigned rcv_idle  = 0;

  tttr_record_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raw_record_i   (raw_record_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .channel_o      (channel_o),
    .event_time_o   (event_time_o),
    .pulse_number_o (pulse_number_o),
    .marker_bits_o  (marker_bits_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Decode one word and advance the origin, as the block does.
  function automatic decoded_t decode_word(logic [tttr_pkg::RECORD_W-1:0] w);
    decoded_t                    r;
    logic                        special;
    logic [tttr_pkg::CHAN_W-1:0] chan;
    logic [tttr_pkg::TIME_W-1:0] tag;
    logic [tttr_pkg::TIME_W-1:0] cnt;
    logic [tttr_pkg::TIME_W-1:0] fine;
    r       = '0;
    special = w[31];
    chan    = w[30:25];
    tag     = 64'(w[tttr_pkg::TAG_W-1:0]);
    cnt     = 64'(w[tttr_pkg::COUNT_W-1:0]);
    fine    = 64'(w[tttr_pkg::FINE_LSB +: tttr_pkg::FINE_W]);
    r.kind  = tttr_pkg::KIND_EVENT;
    if (special && chan == tttr_pkg::OVF_CHANNEL) begin
      origin_q += dec_mode_q ? cnt * 64'(tttr_pkg::PULSE_WRAP)
                             : tag * 64'(tttr_pkg::ABS_WRAP);
      r.kind = tttr_pkg::KIND_OVERFLOW;
    end else if (!dec_mode_q && special && chan == tttr_pkg::SYNC_SPECIAL) begin
      r.channel = sync_ch_q;
      r.ev_time = origin_q + tag;
    end else if (special) begin
      // pulse-relative special channel zero lands here too: marker 0
      r.kind   = tttr_pkg::KIND_MARKER;
      r.marker = chan;
    end else if (!dec_mode_q) begin
      r.channel = 7'(chan);
      r.ev_time = origin_q + tag;
    end else begin
      r.channel = 7'(chan);
      r.pulse   = origin_q + cnt;
      r.ev_time = fine * 64'(bin_ps_q);
    end
    return r;
  endfunction

  function automatic stim_row_t rec_row(logic [tttr_pkg::RECORD_W-1:0] w);
    stim_row_t s;
    s     = '0;
    s.val = w;
    return s;
  endfunction

  function automatic stim_row_t chk_row(logic [tttr_pkg::RECORD_W-1:0] w,
                                        logic [tttr_pkg::KIND_W-1:0] k,
                                        logic [tttr_pkg::OUT_CH_W-1:0] ch,
                                        logic [tttr_pkg::TIME_W-1:0] t,
                                        logic [tttr_pkg::TIME_W-1:0] p,
                                        logic [tttr_pkg::CHAN_W-1:0] m);
    stim_row_t s;
    s       = rec_row(w);
    s.typed = 1'b1;
    s.res   = '{kind: k, channel: ch, ev_time: t, pulse: p, marker: m};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [tttr_pkg::CFG_IDX_W-1:0] idx,
                                        logic [tttr_pkg::CFG_DATA_W-1:0] d);
    stim_row_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.val    = 32'(d);
    return s;
  endfunction

  // Random word, weighted towards well-formed records of each class.
  function automatic logic [tttr_pkg::RECORD_W-1:0] gen_word();
    logic [tttr_pkg::RECORD_W-1:0] w;
    int unsigned                   p;
    w = $urandom;
    p = $urandom_range(99);
    if (p < 45) begin
      w[31] = 1'b0;
    end else if (p < 60) begin
      w[31]    = 1'b1;
      w[30:25] = tttr_pkg::OVF_CHANNEL;
      if ($urandom_range(7) == 0) w[tttr_pkg::TAG_W-1:0] = '0;
    end else if (p < 72) begin
      w[31]    = 1'b1;
      w[30:25] = tttr_pkg::SYNC_SPECIAL;
    end else if (p < 90) begin
      w[31]    = 1'b1;
      w[30:25] = 6'($urandom_range(1, 62));
    end
    return w;
  endfunction

  task automatic cmp_field(string name, logic [tttr_pkg::TIME_W-1:0] exp_v,
                           logic [tttr_pkg::TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Result side: random back-pressure and checking of every accepted word.
  always @(posedge clk_i) begin
    decoded_t e;
    out_ready_i <= ($urandom_range(99) >= rcv_idle);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result word with none expected, kind %h", $time, kind_o);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        cmp_field("kind", 64'(e.kind), 64'(kind_o));
        cmp_field("channel", 64'(e.channel), 64'(channel_o));
        cmp_field("event_time", e.ev_time, event_time_o);
        cmp_field("pulse_number", e.pulse, pulse_number_o);
        cmp_field("marker_bits", 64'(e.marker), 64'(marker_bits_o));
      end
    end
  end

  // Offer one record word, with a random gap first, and log its expectation.
  task automatic push_word(logic [tttr_pkg::RECORD_W-1:0] w, logic typed, decoded_t res);
    decoded_t pred;
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_record_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pred = decode_word(w);
    pending_q.push_back(typed ? res : pred);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tttr_pkg::CFG_IDX_W-1:0] idx,
                           logic [tttr_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      tttr_pkg::CFG_DECODE_MODE:  dec_mode_q = d[0];
      tttr_pkg::CFG_SYNC_CHANNEL: sync_ch_q  = d[tttr_pkg::OUT_CH_W-1:0];
      tttr_pkg::CFG_BIN_WIDTH:    bin_ps_q   = d;
      default: ;
    endcase
  endtask

  initial begin
    stim_row_t                       row;
    logic [tttr_pkg::CFG_DATA_W-1:0] d;
    int unsigned                     ph;
    int unsigned                     seg;
    int unsigned                     n;

    // absolute mode, reset register values
    dir_tab.push_back(chk_row(32'h0000_0000, tttr_pkg::KIND_EVENT, 7'd0, 64'd0, 64'd0,
                              6'd0));
    dir_tab.push_back(chk_row({1'b0, 6'd62, 25'h1FF_FFFF}, tttr_pkg::KIND_EVENT, 7'd62,
                              64'h1FF_FFFF, 64'd0, 6'd0));
    dir_tab.push_back(chk_row({1'b0, 6'd63, 25'd5}, tttr_pkg::KIND_EVENT, 7'd63, 64'd5,
                              64'd0, 6'd0));
    dir_tab.push_back(chk_row({1'b1, tttr_pkg::SYNC_SPECIAL, 25'd123}, tttr_pkg::KIND_EVENT,
                              7'd0, 64'd123, 64'd0, 6'd0));
    dir_tab.push_back(chk_row({1'b1, 6'd1, 25'h1FF_FFFF}, tttr_pkg::KIND_MARKER, 7'd0,
                              64'd0, 64'd0, 6'd1));
    dir_tab.push_back(chk_row({1'b1, 6'd62, 25'd0}, tttr_pkg::KIND_MARKER, 7'd0, 64'd0,
                              64'd0, 6'd62));
    // zero-count overflow leaves the origin alone
    dir_tab.push_back(chk_row({1'b1, tttr_pkg::OVF_CHANNEL, 25'd0}, tttr_pkg::KIND_OVERFLOW,
                              '0, '0, '0, '0));
    dir_tab.push_back(chk_row({1'b1, tttr_pkg::OVF_CHANNEL, 25'd1}, tttr_pkg::KIND_OVERFLOW,
                              '0, '0, '0, '0));
    dir_tab.push_back(rec_row({1'b0, 6'd5, 25'd7}));
    dir_tab.push_back(chk_row({1'b1, tttr_pkg::OVF_CHANNEL, 25'h1FF_FFFF},
                              tttr_pkg::KIND_OVERFLOW, '0, '0, '0, '0));
    dir_tab.push_back(rec_row({1'b0, 6'd33, 25'h1FF_FFFF}));
    // sync channel beyond 64 is reported from its low seven written bits
    dir_tab.push_back(cfg_row(tttr_pkg::CFG_SYNC_CHANNEL, 24'hFF_FF7F));
    dir_tab.push_back(rec_row({1'b1, tttr_pkg::SYNC_SPECIAL, 25'h1FF_FFFF}));
    // pulse-relative mode, zero then widest bin
    dir_tab.push_back(cfg_row(tttr_pkg::CFG_DECODE_MODE, 24'hFF_FFFF));
    dir_tab.push_back(cfg_row(tttr_pkg::CFG_BIN_WIDTH, 24'h00_0000));
    dir_tab.push_back(rec_row({1'b0, 6'd3, 15'h7FFF, 10'd5}));
    dir_tab.push_back(cfg_row(tttr_pkg::CFG_BIN_WIDTH, 24'hFF_FFFF));
    dir_tab.push_back(rec_row({1'b0, 6'd3, 15'h7FFF, 10'h3FF}));
    dir_tab.push_back(chk_row({1'b1, tttr_pkg::SYNC_SPECIAL, 25'h1FF_FFFF},
                              tttr_pkg::KIND_MARKER, '0, '0, '0, 6'd0));
    dir_tab.push_back(chk_row({1'b1, 6'd40, 25'h0AB_CDEF}, tttr_pkg::KIND_MARKER, '0, '0,
                              '0, 6'd40));
    dir_tab.push_back(chk_row({1'b1, tttr_pkg::OVF_CHANNEL, 15'h7FFF, 10'd0},
                              tttr_pkg::KIND_OVERFLOW, '0, '0, '0, '0));
    dir_tab.push_back(chk_row({1'b1, tttr_pkg::OVF_CHANNEL, 15'd0, 10'h3FF},
                              tttr_pkg::KIND_OVERFLOW, '0, '0, '0, '0));
    dir_tab.push_back(rec_row(32'h7FFF_FFFF));
    dir_tab.push_back(cfg_row(CFG_UNUSED, 24'hFF_FFFF));
    dir_tab.push_back(rec_row({1'b0, 6'd0, 15'd1, 10'd0}));
    dir_tab.push_back(cfg_row(tttr_pkg::CFG_DECODE_MODE, 24'h00_0000));
    dir_tab.push_back(cfg_row(tttr_pkg::CFG_SYNC_CHANNEL, 24'h00_0040));
    dir_tab.push_back(rec_row({1'b1, tttr_pkg::SYNC_SPECIAL, 25'd0}));

    snd_idle = 36;
    rcv_idle = 63;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        wait_for_drain();
        repeat (3) @(posedge clk_i);
        write_reg(row.idx, row.val[tttr_pkg::CFG_DATA_W-1:0]);
      end else begin
        push_word(row.val, row.typed, row.res);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle = 36; rcv_idle = 63; end
        1: begin snd_idle = 63; rcv_idle = 36; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      for (seg = 0; seg < 5; seg++) begin
        wait_for_drain();
        repeat (3) @(posedge clk_i);
        write_reg(tttr_pkg::CFG_DECODE_MODE, 24'($urandom));
        d = 24'($urandom);
        case ($urandom_range(3))
          0: d[tttr_pkg::OUT_CH_W-1:0] = 7'd0;
          1: d[tttr_pkg::OUT_CH_W-1:0] = 7'd64;
          2: d[tttr_pkg::OUT_CH_W-1:0] = 7'd127;
          default: ;
        endcase
        write_reg(tttr_pkg::CFG_SYNC_CHANNEL, d);
        case ($urandom_range(3))
          0: d = 24'd0;
          1: d = 24'd1;
          2: d = 24'hFF_FFFF;
          default: d = 24'($urandom);
        endcase
        write_reg(tttr_pkg::CFG_BIN_WIDTH, d);
        if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, 24'($urandom));
        for (n = 0; n < 50; n++) begin
          // now and then hold off until the block has emptied
          if ($urandom_range(99) == 0) wait_for_drain();
          push_word(gen_word(), 1'b0, '0);
        end
      end
    end

    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- tttr_record_decoder.f -----
rtl/tttr_pkg.sv
rtl/tttr_front.sv
rtl/tttr_fifo.sv
rtl/tttr_back.sv
rtl/tttr_record_decoder.sv
tb/tttr_record_decoder_tb.sv
